### src/fba_pkg.sv
// Shared types and constants for the fit block allocator.
package fba_pkg;

  localparam int DEF_NUM_BLOCKS = 32;

  localparam int SIZE_W  = 16;
  localparam int SLOT_W  = 5;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [CFG_W-1:0] BLOCKS_RESET = 6'd32;

  typedef enum logic [1:0] {
    POLICY_FIRST = 2'd0,
    POLICY_BEST  = 2'd1,
    POLICY_WORST = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic load_wr;
    logic scan_en;
    logic charge;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

### src/fba_ctrl.sv
// Controller state machine: sequences the scan and owns the handshakes.
module fba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                opcode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fba_pkg::dp_status_t status,
  output fba_pkg::dp_cmd_t    cmd
);
  import fba_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && opcode == OP_ALLOC) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.start   = in_ready && in_valid && (opcode == OP_ALLOC);
    cmd.load_wr = in_ready && in_valid && (opcode == OP_LOAD);
    cmd.scan_en = (state == ST_SCAN);
    cmd.charge  = (state == ST_REPORT) && (!out_valid || out_ready);
    // The result register is refilled in the same cycle the old result leaves.
    if (cmd.charge) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_report_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.charge |=> out_valid && state == ST_IDLE)
    else $error("result not presented after the report cycle");

  a_alloc_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !in_ready && state == ST_SCAN)
    else $error("allocate transaction did not start a scan");

endmodule

### src/fba_datapath.sv
// Datapath: size table, configuration registers, scan compare and result register.
module fba_datapath #(
  parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
  input  logic [fba_pkg::SLOT_W-1:0]    slot,
  input  logic [fba_pkg::SIZE_W-1:0]    amount,
  input  fba_pkg::dp_cmd_t              cmd,
  output fba_pkg::dp_status_t           status,
  output logic                          granted,
  output logic [fba_pkg::SLOT_W-1:0]    block_index
);
  import fba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  policy_t           policy_mode;
  logic [CFG_W-1:0]  blocks_in_use;

  logic [SIZE_W-1:0] mem [NUM_BLOCKS];
  logic [SIZE_W-1:0] rd_data;

  logic [SIZE_W-1:0] amount_q;
  logic [CNT_W-1:0]  rd_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic              found;
  logic [IDX_W-1:0]  chosen;
  logic [SIZE_W-1:0] chosen_have;
  logic [SIZE_W-1:0] best_left;

  logic [31:0]       limit;
  logic [31:0]       slot_wide;
  logic [31:0]       chosen_wide;
  logic              load_ok;
  logic              issue_now;
  logic              fits;
  logic              take_now;
  logic [SIZE_W-1:0] left;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [SIZE_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= POLICY_FIRST;
      blocks_in_use <= BLOCKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: policy_mode   <= policy_t'(cfg_data[1:0]);
        CFG_BLOCKS: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    limit = (32'(blocks_in_use) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(blocks_in_use);
    slot_wide   = 32'(slot);
    chosen_wide = 32'(chosen);
    load_ok     = cmd.load_wr && (slot_wide < NUM_BLOCKS);

    fits = cmp_valid && (rd_data >= amount_q);
    left = rd_data - amount_q;
    case (policy_mode)
      POLICY_BEST:  take_now = fits && (!found || left < best_left);
      POLICY_WORST: take_now = fits && (!found || left > best_left);
      default:      take_now = fits && !found;
    endcase

    // First fit stops issuing reads as soon as a partition has been taken.
    issue_now = cmd.scan_en && (32'(rd_idx) < limit) &&
                !(!(policy_mode inside {POLICY_BEST, POLICY_WORST}) &&
                  (found || take_now));
    status.scan_done = cmd.scan_en && !issue_now;

    mem_we    = load_ok || (cmd.charge && found);
    mem_waddr = load_ok ? slot_wide[IDX_W-1:0] : chosen;
    mem_wdata = load_ok ? amount : (chosen_have - amount_q);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue_now) rd_data <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.start) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_en) begin
      cmp_valid <= issue_now;
      if (issue_now) rd_idx <= rd_idx + 1'b1;
      if (take_now) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) amount_q <= amount;
    if (issue_now) cmp_idx <= rd_idx[IDX_W-1:0];
    if (take_now) begin
      chosen      <= cmp_idx;
      chosen_have <= rd_data;
      best_left   <= left;
    end
    if (cmd.charge) begin
      granted     <= found;
      block_index <= found ? chosen_wide[SLOT_W-1:0] : '0;
    end
  end

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en && cmp_valid |-> 32'(cmp_idx) < limit)
    else $error("compare index beyond the scanned range");

  a_first_fit_stops: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en && policy_mode == POLICY_FIRST && found |-> status.scan_done)
    else $error("first fit kept scanning after a hit");

endmodule

### src/fit_block_allocator.sv
// Top level of the fit block allocator: controller plus datapath.
//
// Usage: input transactions carry opcode, slot and amount over in_valid/in_ready.
// A load transaction (opcode 0) writes amount into partition slot in the cycle it
// is accepted and produces no result; a slot at or above NUM_BLOCKS is ignored.
// An allocate transaction (opcode 1) scans partitions 0 .. blocks_in_use-1, capped
// at NUM_BLOCKS-1, with one table read per cycle, and charges the chosen
// partition by the request. The result (granted, block_index) leaves over
// out_valid/out_ready. Loads can be accepted back to back, but no transaction is
// accepted while an allocate scans or reports; the scan is paced by the single
// read port of the size table, and first fit ends its scan at the first hit.
// The configuration port (cfg_we, cfg_index, cfg_data) writes policy_mode
// (index 0) and blocks_in_use (index 1); write it only while idle.
// Reset clears the controller and sets first fit with blocks_in_use at 32; the
// size table is not cleared, so load every scanned partition before allocating.
// When the receiver stalls, the result waits in the output register while load
// transactions are still accepted; a following allocate scans, then holds its
// result and the input until the first result has been taken.
module fit_block_allocator #(
  parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [fba_pkg::SLOT_W-1:0]    slot,
  input  logic [fba_pkg::SIZE_W-1:0]    amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          granted,
  output logic [fba_pkg::SLOT_W-1:0]    block_index
);
  import fba_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slot        (slot),
    .amount      (amount),
    .cmd         (cmd),
    .status      (status),
    .granted     (granted),
    .block_index (block_index)
  );

endmodule
